@@ design/sync_frame_command_receiver_top_macros.svh @@
// Assertion macros for the sync frame command receiver.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef SYNC_FRAME_COMMAND_RECEIVER_TOP_MACROS_SVH
`define SYNC_FRAME_COMMAND_RECEIVER_TOP_MACROS_SVH

// Implication checked in the same cycle.
`define SFCR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Implication checked in the cycle after the antecedent.
`define SFCR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/sfcr_pkg.sv @@
// Shared types and constants for the sync frame command receiver.
// No dependencies.
package sfcr_pkg;

  localparam int FRAME_LIMIT_DEF = 64;
  localparam int QUEUE_DEPTH     = 2;
  localparam int REPLY_COUNT     = 19;
  localparam int REPLY_HDR_LEN   = 3;
  localparam int NUM_PARAMS      = 4;
  localparam int OUT_TDATA_W     = 48;

  localparam logic [7:0] SYNC_FIRST     = 8'hFF;
  localparam logic [7:0] SYNC_SECOND    = 8'h55;
  localparam logic [7:0] REPLY_LEN_BYTE = 8'h10;
  localparam logic [7:0] CMD_PARAM_LO   = 8'h01;
  localparam logic [7:0] CMD_PARAM_HI   = 8'h04;
  localparam logic [7:0] CMD_REPLY      = 8'h05;

  typedef struct packed {
    logic         is_reply;
    logic [1:0]   sel;
    logic [127:0] data;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } push_t;

endpackage

@@ design/sync_frame_command_receiver_top.sv @@
// Sync frame command receiver: deframes FF 55 <len> <payload> command frames.
// Input bytes are taken one per cycle while the job queue has room.
// The closing byte's job passes through the queue and the back part's job register
// into the output register; the back part then issues one result per cycle while the
// output is ready (19 for a reply, 1 for an update), and none while it takes the next job.
// Synchronous active-low reset clears the frame state, parameters, queue and output valid.
module sync_frame_command_receiver_top #(
  parameter int FRAME_LIMIT = sfcr_pkg::FRAME_LIMIT_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [7:0]                       in_tdata,   // [7:0] rx_byte
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [sfcr_pkg::OUT_TDATA_W-1:0] out_tdata,  // [7:0] tx_byte, [9:8] param_select,
                                                       // [41:10] param_value
  output logic                             out_tuser,  // [0] out_kind
  output logic                             out_tlast
);

  sfcr_pkg::push_t push;
  sfcr_pkg::job_t  q_job;
  logic            full;
  logic            q_valid;
  logic            q_ready;
  logic            acc;

  assign in_tready = !full;
  assign acc       = in_tvalid && in_tready;

  sfcr_front #(
    .FRAME_LIMIT(FRAME_LIMIT)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .acc    (acc),
    .rx_byte(in_tdata),
    .push   (push)
  );

  sfcr_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .full   (full),
    .q_valid(q_valid),
    .q_ready(q_ready),
    .q_job  (q_job)
  );

  sfcr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_job     (q_job),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

`include "sync_frame_command_receiver_top_macros.svh"

  `SFCR_ASSERT_NOW(a_no_push_when_full, push.valid, !full, "job pushed into a full queue")
  `SFCR_ASSERT_NOW(a_update_is_last, out_tvalid && out_tuser, out_tlast, "update not last")
  `SFCR_ASSERT_NOW(a_reply_clear, out_tvalid && !out_tuser, out_tdata[41:8] == '0, "reply fields")
  `SFCR_ASSERT_NEXT(a_pop_starts_job, q_valid && q_ready, !q_ready, "back part did not take the job")

endmodule

@@ design/sfcr_front.sv @@
// Front part: tracks the frame state byte by byte and queues a job per completed parameter or reply command.
// Depends on sfcr_pkg.
module sfcr_front #(
  parameter int FRAME_LIMIT = sfcr_pkg::FRAME_LIMIT_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                acc,
  input  logic [7:0]          rx_byte,
  output sfcr_pkg::push_t     push
);

  localparam int PW = $clog2(FRAME_LIMIT + 1);

  logic          in_frame_r, in_frame_nxt;
  logic [7:0]    prev_r, prev_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic [7:0]    rem_r, rem_nxt;
  logic [7:0]    pay_r [5];
  logic [7:0]    pay_nxt [5];
  logic [31:0]   words_r [sfcr_pkg::NUM_PARAMS];
  logic [31:0]   words_nxt [sfcr_pkg::NUM_PARAMS];
  logic          done;
  logic [7:0]    cmd;
  logic          is_param;
  logic          is_reply;
  logic [1:0]    sel;
  logic [31:0]   word;

  always_comb begin
    in_frame_nxt = in_frame_r;
    prev_nxt     = prev_r;
    pos_nxt      = pos_r;
    rem_nxt      = rem_r;
    pay_nxt      = pay_r;
    words_nxt    = words_r;
    if (rx_byte == sfcr_pkg::SYNC_SECOND && !in_frame_r) begin
      if (prev_r == sfcr_pkg::SYNC_FIRST) begin
        pos_nxt      = PW'(1);
        in_frame_nxt = 1'b1;
      end
    end else begin
      prev_nxt = rx_byte;
      if (in_frame_r) begin
        if (pos_r == PW'(2)) begin
          rem_nxt = rx_byte;
        end else if (pos_r > PW'(2)) begin
          rem_nxt = rem_r - 8'd1;
        end
        for (int i = 0; i < 5; i++) begin
          if (pos_r == PW'(i + 3)) begin
            pay_nxt[i] = rx_byte;
          end
        end
      end
    end
    pos_nxt = pos_nxt + PW'(1);
    if (pos_nxt > PW'(FRAME_LIMIT - 1)) begin
      pos_nxt      = '0;
      in_frame_nxt = 1'b0;
    end
    done     = in_frame_nxt && (rem_nxt == 8'd0) && (pos_nxt > PW'(3));
    cmd      = pay_nxt[4];
    is_param = (cmd >= sfcr_pkg::CMD_PARAM_LO) && (cmd <= sfcr_pkg::CMD_PARAM_HI);
    is_reply = (cmd == sfcr_pkg::CMD_REPLY);
    sel      = 2'(cmd - sfcr_pkg::CMD_PARAM_LO);
    word     = {pay_nxt[3], pay_nxt[2], pay_nxt[1], pay_nxt[0]};
    if (done) begin
      pos_nxt      = '0;
      in_frame_nxt = 1'b0;
      if (is_param) begin
        for (int i = 0; i < sfcr_pkg::NUM_PARAMS; i++) begin
          if (sel == 2'(i)) begin
            words_nxt[i] = word;
          end
        end
      end
    end
    push.valid        = acc && done && (is_param || is_reply);
    push.job.is_reply = is_reply;
    push.job.sel      = is_reply ? 2'd0 : sel;
    push.job.data     = is_reply ? {words_r[3], words_r[2], words_r[1], words_r[0]}
                                 : {96'd0, word};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      prev_r     <= '0;
      pos_r      <= '0;
      rem_r      <= '0;
      for (int i = 0; i < 5; i++) begin
        pay_r[i] <= '0;
      end
      for (int i = 0; i < sfcr_pkg::NUM_PARAMS; i++) begin
        words_r[i] <= '0;
      end
    end else if (acc) begin
      in_frame_r <= in_frame_nxt;
      prev_r     <= prev_nxt;
      pos_r      <= pos_nxt;
      rem_r      <= rem_nxt;
      pay_r      <= pay_nxt;
      words_r    <= words_nxt;
    end
  end

endmodule

@@ design/sfcr_queue.sv @@
// Short job queue between the front and back parts.
// Depends on sfcr_pkg.
module sfcr_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  sfcr_pkg::push_t  push,
  output logic             full,
  output logic             q_valid,
  input  logic             q_ready,
  output sfcr_pkg::job_t   q_job
);

  localparam int QAW = $clog2(sfcr_pkg::QUEUE_DEPTH);
  localparam int CW  = $clog2(sfcr_pkg::QUEUE_DEPTH + 1);

  sfcr_pkg::job_t mem_r [sfcr_pkg::QUEUE_DEPTH];
  logic [QAW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]  count_r;
  logic           do_push;
  logic           do_pop;

  assign full    = (count_r == CW'(sfcr_pkg::QUEUE_DEPTH));
  assign q_valid = (count_r != '0);
  assign q_job   = mem_r[rd_ptr_r];
  assign do_push = push.valid && !full;
  assign do_pop  = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push.job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == QAW'(sfcr_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QAW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QAW'(sfcr_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QAW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CW'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

endmodule

@@ design/sfcr_back.sv @@
// Back part: turns queued jobs into result transactions through an output register.
// Depends on sfcr_pkg.
module sfcr_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                q_valid,
  output logic                                q_ready,
  input  sfcr_pkg::job_t                      q_job,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [sfcr_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic                                out_tuser,
  output logic                                out_tlast
);

  localparam int IW = $clog2(sfcr_pkg::REPLY_COUNT);

  logic                             busy_r;
  sfcr_pkg::job_t                   job_r;
  logic [IW-1:0]                    idx_r;
  logic                             out_tvalid_r;
  logic [sfcr_pkg::OUT_TDATA_W-1:0] out_tdata_r;
  logic                             out_tuser_r;
  logic                             out_tlast_r;
  logic                             adv;
  logic                             is_last;
  logic [3:0]                       bsel;
  logic [7:0]                       tx_byte;

  assign adv     = !out_tvalid_r || out_tready;
  assign q_ready = !busy_r;
  assign is_last = job_r.is_reply ? (idx_r == IW'(sfcr_pkg::REPLY_COUNT - 1)) : 1'b1;
  assign bsel    = 4'(idx_r - IW'(sfcr_pkg::REPLY_HDR_LEN));

  always_comb begin
    if (idx_r == IW'(0)) begin
      tx_byte = sfcr_pkg::SYNC_FIRST;
    end else if (idx_r == IW'(1)) begin
      tx_byte = sfcr_pkg::SYNC_SECOND;
    end else if (idx_r == IW'(2)) begin
      tx_byte = sfcr_pkg::REPLY_LEN_BYTE;
    end else begin
      tx_byte = job_r.data[8*bsel +: 8];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      idx_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (!busy_r) begin
        if (out_tready) begin
          out_tvalid_r <= 1'b0;
        end
        if (q_valid) begin
          job_r  <= q_job;
          idx_r  <= '0;
          busy_r <= 1'b1;
        end
      end else if (adv) begin
        out_tvalid_r <= 1'b1;
        out_tlast_r  <= is_last;
        if (job_r.is_reply) begin
          out_tuser_r <= 1'b0;
          out_tdata_r <= {40'd0, tx_byte};
        end else begin
          out_tuser_r <= 1'b1;
          out_tdata_r <= {6'd0, job_r.data[31:0], job_r.sel, 8'd0};
        end
        if (is_last) begin
          busy_r <= 1'b0;
        end else begin
          idx_r <= idx_r + IW'(1);
        end
      end
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;
  assign out_tlast  = out_tlast_r;

endmodule

@@ sim/tb.sv @@
// Testbench for sync_frame_command_receiver_top: a directed table of frames, then random
// frames, broken headers and noise, checked against the table's results or a deframer predictor.
// Depends on sfcr_pkg and the top level only.
module tb;

  localparam int CLK_HALF         = 6;
  localparam int TOTAL_ITEMS      = 480;
  localparam int DIRECTED_ROWS    = 29;
  localparam int STALL_LIMIT      = 1000;
  localparam int DRAIN_CYCLES     = 12;
  localparam int SHOWN_MISMATCHES = 10;
  localparam int PAD_LO           = 42;

  typedef struct packed {
    logic        kind;
    logic [7:0]  tx;
    logic [1:0]  sel;
    logic [31:0] val;
    logic        last;
  } frame_result_t;

  typedef struct packed {
    logic [7:0]  rx;
    logic        typed;
    logic        has_result;
    logic [1:0]  sel;
    logic [31:0] val;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [7:0] in_tdata = 8'h00;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [sfcr_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic out_tuser;
  logic out_tlast;

  frame_result_t pending_results[$];
  int items_sent = 0;
  int mismatches = 0;
  int quiet_cycles = 0;

  logic        framing = 1'b0;
  logic [7:0]  prev_rx = 8'h00;
  int          frame_pos = 0;
  logic [7:0]  bytes_left = 8'h00;
  logic [7:0]  frame_bytes[5] = '{default: 8'h00};
  logic [31:0] param_words[sfcr_pkg::NUM_PARAMS] = '{default: 32'h0};

  stim_row_t directed_rows[DIRECTED_ROWS] = '{
    '{8'h55, 1'b1, 1'b0, 2'd0, 32'h0},
    '{8'hFF, 1'b1, 1'b0, 2'd0, 32'h0},
    '{8'h55, 1'b1, 1'b0, 2'd0, 32'h0},
    '{8'h05, 1'b1, 1'b0, 2'd0, 32'h0},
    '{8'h78, 1'b1, 1'b0, 2'd0, 32'h0},
    '{8'h56, 1'b1, 1'b0, 2'd0, 32'h0},
    '{8'h34, 1'b1, 1'b0, 2'd0, 32'h0},
    '{8'h12, 1'b1, 1'b0, 2'd0, 32'h0},
    '{8'h01, 1'b1, 1'b1, 2'd0, 32'h12345678},
    '{8'hFF, 1'b1, 1'b0, 2'd0, 32'h0},
    '{8'h55, 1'b1, 1'b0, 2'd0, 32'h0},
    '{8'h05, 1'b1, 1'b0, 2'd0, 32'h0},
    '{8'hFF, 1'b1, 1'b0, 2'd0, 32'h0},
    '{8'hFF, 1'b1, 1'b0, 2'd0, 32'h0},
    '{8'hFF, 1'b1, 1'b0, 2'd0, 32'h0},
    '{8'hFF, 1'b1, 1'b0, 2'd0, 32'h0},
    '{8'h04, 1'b1, 1'b1, 2'd3, 32'hFFFFFFFF},
    '{8'hFF, 1'b0, 1'b0, 2'd0, 32'h0},
    '{8'h55, 1'b0, 1'b0, 2'd0, 32'h0},
    '{8'h01, 1'b0, 1'b0, 2'd0, 32'h0},
    '{8'hAA, 1'b0, 1'b0, 2'd0, 32'h0},
    '{8'hFF, 1'b0, 1'b0, 2'd0, 32'h0},
    '{8'h55, 1'b0, 1'b0, 2'd0, 32'h0},
    '{8'h05, 1'b0, 1'b0, 2'd0, 32'h0},
    '{8'h00, 1'b0, 1'b0, 2'd0, 32'h0},
    '{8'h00, 1'b0, 1'b0, 2'd0, 32'h0},
    '{8'h00, 1'b0, 1'b0, 2'd0, 32'h0},
    '{8'h00, 1'b0, 1'b0, 2'd0, 32'h0},
    '{8'h05, 1'b0, 1'b0, 2'd0, 32'h0}
  };

  sync_frame_command_receiver_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #CLK_HALF clk = ~clk;

  function automatic int sender_idle_pct();
    case (items_sent * 3 / TOTAL_ITEMS)
      0: return 35;
      1: return 71;
      default: return 0;
    endcase
  endfunction

  function automatic int receiver_idle_pct();
    case (items_sent * 3 / TOTAL_ITEMS)
      0: return 71;
      1: return 35;
      default: return 0;
    endcase
  endfunction

  task automatic advance_deframer(input logic [7:0] b, input bit keep);
    logic [7:0] cmd;
    logic [31:0] word;
    logic [1:0] slot;
    logic [7:0] reply_bytes[sfcr_pkg::REPLY_COUNT];
    frame_result_t r;
    int i, j;
    if (b == sfcr_pkg::SYNC_SECOND && !framing) begin
      if (prev_rx == sfcr_pkg::SYNC_FIRST) begin
        frame_pos = 1;
        framing = 1'b1;
      end
    end else begin
      prev_rx = b;
      if (framing) begin
        if (frame_pos == 2) begin
          bytes_left = b;
        end else if (frame_pos > 2) begin
          bytes_left = bytes_left - 8'd1;
        end
        if (frame_pos >= 3 && frame_pos <= 7) begin
          frame_bytes[frame_pos - 3] = b;
        end
      end
    end
    frame_pos++;
    if (frame_pos > sfcr_pkg::FRAME_LIMIT_DEF - 1) begin
      frame_pos = 0;
      framing = 1'b0;
    end
    if (framing && bytes_left == 8'd0 && frame_pos > 3) begin
      cmd = frame_bytes[4];
      frame_pos = 0;
      framing = 1'b0;
      if (cmd >= sfcr_pkg::CMD_PARAM_LO && cmd <= sfcr_pkg::CMD_PARAM_HI) begin
        slot = 2'(cmd - sfcr_pkg::CMD_PARAM_LO);
        word = {frame_bytes[3], frame_bytes[2], frame_bytes[1], frame_bytes[0]};
        param_words[slot] = word;
        r = '{1'b1, 8'h00, slot, word, 1'b1};
        if (keep) pending_results.push_back(r);
      end else if (cmd == sfcr_pkg::CMD_REPLY && keep) begin
        reply_bytes[0] = sfcr_pkg::SYNC_FIRST;
        reply_bytes[1] = sfcr_pkg::SYNC_SECOND;
        reply_bytes[2] = sfcr_pkg::REPLY_LEN_BYTE;
        for (i = 0; i < sfcr_pkg::NUM_PARAMS; i++) begin
          for (j = 0; j < 4; j++) begin
            reply_bytes[sfcr_pkg::REPLY_HDR_LEN + 4 * i + j] = param_words[i][8 * j +: 8];
          end
        end
        for (i = 0; i < sfcr_pkg::REPLY_COUNT; i++) begin
          r = '{1'b0, reply_bytes[i], 2'd0, 32'h0, i == sfcr_pkg::REPLY_COUNT - 1};
          pending_results.push_back(r);
        end
      end
    end
  endtask

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < sender_idle_pct()) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_predicted(input logic [7:0] b);
    send_byte(b);
    advance_deframer(b, 1'b1);
  endtask

  // Mostly well-formed frames with random content; the rest are runaway frames
  // that hit the position limit, broken headers and plain noise.
  task automatic send_random_sequence();
    int pick, len, n, k, r;
    logic [7:0] cmd;
    pick = $urandom_range(0, 99);
    if (pick < 62) begin
      len = ($urandom_range(0, 9) < 8) ? 5 : $urandom_range(1, 9);
      r = $urandom_range(0, 9);
      if (r < 3) begin
        cmd = sfcr_pkg::CMD_REPLY;
      end else if (r < 8) begin
        cmd = 8'($urandom_range(sfcr_pkg::CMD_PARAM_LO, sfcr_pkg::CMD_PARAM_HI));
      end else begin
        cmd = 8'($urandom_range(0, 255));
      end
      send_predicted(sfcr_pkg::SYNC_FIRST);
      send_predicted(sfcr_pkg::SYNC_SECOND);
      send_predicted(8'(len));
      for (k = 0; k < len; k++) begin
        send_predicted((k == 4) ? cmd : 8'($urandom_range(0, 255)));
      end
    end else if (pick < 66) begin
      send_predicted(sfcr_pkg::SYNC_FIRST);
      send_predicted(sfcr_pkg::SYNC_SECOND);
      send_predicted($urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(58, 255)));
      n = $urandom_range(50, 66);
      for (k = 0; k < n; k++) send_predicted(8'($urandom_range(0, 255)));
    end else if (pick < 84) begin
      n = $urandom_range(1, 3);
      for (k = 0; k < n; k++) begin
        r = $urandom_range(0, 2);
        send_predicted((r == 0) ? sfcr_pkg::SYNC_FIRST :
                       (r == 1) ? sfcr_pkg::SYNC_SECOND : 8'($urandom_range(0, 255)));
      end
    end else begin
      n = $urandom_range(1, 6);
      for (k = 0; k < n; k++) send_predicted(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic note_mismatch(input string what, input frame_result_t want);
    mismatches++;
    if (mismatches <= SHOWN_MISMATCHES) begin
      $display("%s: expected kind %0d tx %02h sel %0d value %08h last %0d", what,
               want.kind, want.tx, want.sel, want.val, want.last);
      $display("  got kind %0d tx %02h sel %0d value %08h last %0d pad %h", out_tuser,
               out_tdata[7:0], out_tdata[9:8], out_tdata[41:10], out_tlast,
               out_tdata[sfcr_pkg::OUT_TDATA_W-1:PAD_LO]);
    end
  endtask

  initial begin
    frame_result_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        if (pending_results.size() == 0) begin
          note_mismatch("Unexpected transaction", '0);
        end else begin
          want = pending_results.pop_front();
          if (out_tuser !== want.kind || out_tdata[7:0] !== want.tx ||
              out_tdata[9:8] !== want.sel || out_tdata[41:10] !== want.val ||
              out_tlast !== want.last ||
              out_tdata[sfcr_pkg::OUT_TDATA_W-1:PAD_LO] !== '0) begin
            note_mismatch("Field mismatch", want);
          end
        end
      end
      out_tready <= ($urandom_range(0, 99) >= receiver_idle_pct());
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    frame_result_t typed_result;
    int k;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    for (k = 0; k < DIRECTED_ROWS; k++) begin
      send_byte(directed_rows[k].rx);
      if (directed_rows[k].typed) begin
        advance_deframer(directed_rows[k].rx, 1'b0);
        if (directed_rows[k].has_result) begin
          typed_result = '{1'b1, 8'h00, directed_rows[k].sel, directed_rows[k].val, 1'b1};
          pending_results.push_back(typed_result);
        end
      end else begin
        advance_deframer(directed_rows[k].rx, 1'b1);
      end
    end
    while (items_sent < TOTAL_ITEMS) send_random_sequence();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
